// ===== rtl/core/ccrp_pkg.sv =====
// shared types, constants and arithmetic helpers of the raft packer
`default_nettype none
package ccrp_pkg;

	localparam logic [31:0] RAFT_BYTES = 32'd1048576;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_BEGIN  = 2'd0,
		OP_CHUNK  = 2'd1,
		OP_FINISH = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CLS_BEGIN,
		CLS_CHUNK,
		CLS_FINISH
	} cls_t;

	typedef enum logic [1:0] {
		KIND_COPY   = 2'd0,
		KIND_PATCH  = 2'd1,
		KIND_REJECT = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CFG_MAX_STREAM = 2'd0,
		CFG_MIN_POST   = 2'd1,
		CFG_SIZE_ALIGN = 2'd2,
		CFG_ADDR_ALIGN = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_PATCH,
		ST_FREE,
		ST_REMAIN,
		ST_ROOM,
		ST_PLACE,
		ST_DONE
	} exec_state_t;

	typedef struct packed {
		cls_t        cls;
		logic [31:0] chunk_bytes;
		logic [31:0] chunk_total_bytes;
		logic [31:0] chunk_src_offset;
		logic [47:0] chunk_addr;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] raft_offset;
		logic [31:0] length;
		logic [31:0] src_offset;
		logic [47:0] target_addr;
		logic [31:0] target_bytes;
		logic [31:0] launch_bytes;
		logic        last;
	} result_t;

	function automatic logic [31:0] sat32(input logic [32:0] v);
		return v[32] ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [31:0] sub0(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? (a - b) : 32'd0;
	endfunction

	function automatic logic [31:0] min32(input logic [31:0] a, input logic [31:0] b);
		return (a < b) ? a : b;
	endfunction

	// round up to 2**lg, saturating at the top of the 32-bit range
	function automatic logic [31:0] align_up(input logic [32:0] v, input logic [4:0] lg);
		logic [33:0] m;
		logic [33:0] s;
		m = (34'd1 << lg) - 34'd1;
		s = ({1'b0, v} + m) & ~m;
		return (s > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ccrp_front.sv =====
// front end: accepts requests, classifies the op, drops no-ops, queues the rest
`default_nettype none
module ccrp_front
	import ccrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] chunk_bytes,
	input  wire logic [31:0] chunk_total_bytes,
	input  wire logic [31:0] chunk_src_offset,
	input  wire logic [47:0] chunk_addr,
	output logic             item_valid,
	output item_t            item,
	input  wire logic        item_pop
);

	item_t             mem_q [IQ_DEPTH];
	logic [IQ_AW-1:0]  wr_ptr_q;
	logic [IQ_AW-1:0]  rd_ptr_q;
	logic [IQ_CW-1:0]  count_q;
	logic              accept;
	logic              keep;
	logic              take;
	item_t             new_item;
	op_t               op_in;

	assign full       = (count_q == IQ_CW'(IQ_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign accept     = push && !full;
	assign op_in      = op_t'(op);
	assign take       = item_pop && item_valid;

	always_comb begin
		new_item.chunk_bytes       = chunk_bytes;
		new_item.chunk_total_bytes = chunk_total_bytes;
		new_item.chunk_src_offset  = chunk_src_offset;
		new_item.chunk_addr        = chunk_addr;
		new_item.cls               = CLS_BEGIN;
		keep                       = 1'b1;
		unique case (op_in)
			OP_BEGIN:  new_item.cls = CLS_BEGIN;
			OP_CHUNK:  new_item.cls = CLS_CHUNK;
			OP_FINISH: new_item.cls = CLS_FINISH;
			OP_NOP:    keep = 1'b0;
			default:   keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept && keep) begin
				wr_ptr_q <= (wr_ptr_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == IQ_AW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({accept && keep, take})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ccrp_exec.sv =====
// back end: layout state, configuration registers and the close/place sequencer
`default_nettype none
module ccrp_exec
	import ccrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        item_valid,
	input  item_t            item,
	output logic             item_pop,
	input  wire logic        res_full,
	output logic             res_push,
	output result_t          res
);

	// configuration
	logic [31:0] max_stream_q;
	logic [15:0] min_post_q;
	logic [4:0]  size_align_q;
	logic [4:0]  addr_align_q;

	// layout state
	logic [31:0] free_off_q;
	logic [31:0] open_off_q;
	logic [31:0] open_used_q;
	logic [31:0] open_room_q;
	logic [31:0] pend_off_q;
	logic [31:0] pend_size_q;
	logic [31:0] first_bytes_q;
	logic        closed_q;

	// sequencer scratch
	exec_state_t state_q;
	exec_state_t state_d;
	item_t       cur_q;
	logic [31:0] total_q;
	logic [31:0] remain_q;
	logic [31:0] post_al_q;

	item_t       it;
	logic        fits;
	logic        idle_take;
	logic [31:0] begin_room;

	assign cfg_ready  = 1'b1;
	assign it         = (state_q == ST_IDLE) ? item : cur_q;
	assign fits       = !(it.chunk_bytes > open_room_q);
	assign idle_take  = item_valid && !res_full;
	assign begin_room = sub0(min32(max_stream_q, RAFT_BYTES), {16'd0, min_post_q});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (idle_take) begin
					if (item.cls == CLS_FINISH && open_used_q != '0) begin
						state_d = ST_TOTAL;
					end else if (item.cls == CLS_CHUNK && !closed_q && !fits) begin
						state_d = ST_TOTAL;
					end
				end
			end
			ST_TOTAL:  state_d = ST_PATCH;
			ST_PATCH: begin
				if (pend_size_q == '0 || !res_full) begin
					state_d = ST_FREE;
				end
			end
			ST_FREE:   state_d = (cur_q.cls == CLS_FINISH) ? ST_DONE : ST_REMAIN;
			ST_REMAIN: state_d = ST_ROOM;
			ST_ROOM:   state_d = ST_PLACE;
			ST_PLACE:  if (!res_full) state_d = ST_IDLE;
			ST_DONE:   if (!res_full) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_pop = 1'b0;
		res_push = 1'b0;
		res      = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_pop = idle_take;
				if (idle_take) begin
					unique case (item.cls)
						CLS_FINISH: begin
							if (open_used_q == '0) begin
								res_push         = 1'b1;
								res.kind         = KIND_DONE;
								res.launch_bytes = first_bytes_q;
								res.last         = 1'b1;
							end
						end
						CLS_CHUNK: begin
							if (closed_q) begin
								res_push = 1'b1;
								res.kind = KIND_REJECT;
								res.last = 1'b1;
							end else if (fits) begin
								res_push        = 1'b1;
								res.kind        = KIND_COPY;
								res.raft_offset = free_off_q;
								res.length      = it.chunk_bytes;
								res.src_offset  = it.chunk_src_offset;
								res.last        = 1'b1;
							end
						end
						default: res_push = 1'b0;
					endcase
				end
			end
			ST_PATCH: begin
				if (pend_size_q != '0 && !res_full) begin
					res_push         = 1'b1;
					res.kind         = KIND_PATCH;
					res.raft_offset  = pend_off_q;
					res.length       = pend_size_q;
					res.target_addr  = {16'd0, open_off_q};
					res.target_bytes = total_q;
				end
			end
			ST_PLACE: begin
				if (!res_full) begin
					res_push = 1'b1;
					res.last = 1'b1;
					if (fits) begin
						res.kind        = KIND_COPY;
						res.raft_offset = free_off_q;
						res.length      = it.chunk_bytes;
						res.src_offset  = it.chunk_src_offset;
					end else begin
						// no room left: chain straight to the chunk and close the stream
						res.kind         = KIND_PATCH;
						res.raft_offset  = pend_off_q;
						res.length       = pend_size_q;
						res.target_addr  = it.chunk_addr;
						res.target_bytes = it.chunk_total_bytes;
					end
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					res_push         = 1'b1;
					res.kind         = KIND_DONE;
					res.raft_offset  = pend_off_q;
					res.length       = pend_size_q;
					res.launch_bytes = first_bytes_q;
					res.last         = 1'b1;
				end
			end
			default: res_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && idle_take) begin
			cur_q <= item;
		end
		if (state_q == ST_TOTAL) begin
			total_q <= align_up({1'b0, open_used_q} + {17'd0, min_post_q}, size_align_q);
		end
		if (state_q == ST_REMAIN) begin
			remain_q  <= sub0(RAFT_BYTES, free_off_q);
			post_al_q <= align_up({17'd0, min_post_q}, size_align_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_stream_q  <= 32'd1048576;
			min_post_q    <= 16'd16;
			size_align_q  <= 5'd2;
			addr_align_q  <= 5'd2;
			free_off_q    <= '0;
			open_off_q    <= '0;
			open_used_q   <= '0;
			open_room_q   <= '0;
			pend_off_q    <= '0;
			pend_size_q   <= '0;
			first_bytes_q <= '0;
			closed_q      <= 1'b0;
			state_q       <= ST_IDLE;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					CFG_MAX_STREAM: max_stream_q <= cfg_data;
					CFG_MIN_POST:   min_post_q   <= cfg_data[15:0];
					CFG_SIZE_ALIGN: size_align_q <= cfg_data[4:0];
					CFG_ADDR_ALIGN: addr_align_q <= cfg_data[4:0];
					default:        max_stream_q <= max_stream_q;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (idle_take) begin
						unique case (item.cls)
							CLS_BEGIN: begin
								free_off_q    <= '0;
								open_off_q    <= '0;
								open_used_q   <= '0;
								open_room_q   <= begin_room;
								pend_off_q    <= '0;
								pend_size_q   <= '0;
								first_bytes_q <= '0;
								closed_q      <= 1'b0;
							end
							CLS_FINISH: begin
								if (open_used_q == '0) closed_q <= 1'b1;
							end
							CLS_CHUNK: begin
								if (!closed_q && fits) begin
									free_off_q  <= sat32({1'b0, free_off_q} + {1'b0, it.chunk_bytes});
									open_used_q <= sat32({1'b0, open_used_q} + {1'b0, it.chunk_bytes});
									open_room_q <= open_room_q - it.chunk_bytes;
								end
							end
							default: closed_q <= closed_q;
						endcase
					end
				end
				ST_PATCH: begin
					if (pend_size_q == '0 || !res_full) begin
						if (first_bytes_q == '0) first_bytes_q <= total_q;
						pend_off_q  <= free_off_q;
						pend_size_q <= sub0(total_q, open_used_q);
						open_off_q  <= '0;
						open_used_q <= '0;
						open_room_q <= '0;
					end
				end
				ST_FREE: begin
					free_off_q <= align_up({1'b0, free_off_q} + {1'b0, pend_size_q}, addr_align_q);
				end
				ST_ROOM: begin
					if (remain_q > post_al_q) begin
						open_off_q  <= free_off_q;
						open_room_q <= sub0(min32(max_stream_q, remain_q), {16'd0, min_post_q});
					end
				end
				ST_PLACE: begin
					if (!res_full) begin
						if (fits) begin
							free_off_q  <= sat32({1'b0, free_off_q} + {1'b0, it.chunk_bytes});
							open_used_q <= sat32({1'b0, open_used_q} + {1'b0, it.chunk_bytes});
							open_room_q <= open_room_q - it.chunk_bytes;
						end else begin
							closed_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (!res_full) closed_q <= 1'b1;
				end
				default: closed_q <= closed_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/ccrp_outq.sv =====
// result queue between the sequencer and the result ports
`default_nettype none
module ccrp_outq
	import ccrp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	input  result_t   res_in,
	output logic      res_full,
	input  wire logic pop,
	output logic      empty,
	output result_t   res_out
);

	result_t           mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_ptr_q;
	logic [OQ_AW-1:0]  rd_ptr_q;
	logic [OQ_CW-1:0]  count_q;
	logic              wr;
	logic              rd;

	assign res_full = (count_q == OQ_CW'(OQ_DEPTH));
	assign empty    = (count_q == '0);
	assign res_out  = mem_q[rd_ptr_q];
	assign wr       = res_push && !res_full;
	assign rd       = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/command_chunk_raft_packer.sv =====
// top level of the command chunk raft packer
//
//   channel   handshake              payload
//   request   push / full            op, chunk_bytes, chunk_total_bytes, chunk_src_offset,
//                                    chunk_addr
//   result    empty / pop            kind, raft_offset, length, src_offset, target_addr,
//                                    target_bytes, launch_bytes, last
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// a chunk that fits, a begin, a rejected chunk, or a finish on an empty buffer is handled
// in the accept step alone; a no-op is dropped at the front and never reaches the
// sequencer. closing a buffer steps through accept, size, patch, free offset, remaining
// space, room and place for a chunk, and through accept, size, patch, free offset and
// done for a finish. a two-entry request queue and a four-entry result queue decouple
// the ports from the sequencer; it stalls only when the result queue is full. reset
// clears layout state and loads the configuration defaults.
`default_nettype none
module command_chunk_raft_packer
	import ccrp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  op,
	input  wire logic [31:0] chunk_bytes,
	input  wire logic [31:0] chunk_total_bytes,
	input  wire logic [31:0] chunk_src_offset,
	input  wire logic [47:0] chunk_addr,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic [31:0]      raft_offset,
	output logic [31:0]      length,
	output logic [31:0]      src_offset,
	output logic [47:0]      target_addr,
	output logic [31:0]      target_bytes,
	output logic [31:0]      launch_bytes,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic    item_valid;
	item_t   item;
	logic    item_pop;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	result_t res_out;

	ccrp_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.op                (op),
		.chunk_bytes       (chunk_bytes),
		.chunk_total_bytes (chunk_total_bytes),
		.chunk_src_offset  (chunk_src_offset),
		.chunk_addr        (chunk_addr),
		.item_valid        (item_valid),
		.item              (item),
		.item_pop          (item_pop)
	);

	ccrp_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	ccrp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.res_full (res_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign kind         = res_out.kind;
	assign raft_offset  = res_out.raft_offset;
	assign length       = res_out.length;
	assign src_offset   = res_out.src_offset;
	assign target_addr  = res_out.target_addr;
	assign target_bytes = res_out.target_bytes;
	assign launch_bytes = res_out.launch_bytes;
	assign last         = res_out.last;

endmodule
`default_nettype wire

// ===== tb/tb_command_chunk_raft_packer.sv =====
// testbench for the raft packer: directed and random chunk streams checked against a layout predictor
`default_nettype none
module tb_command_chunk_raft_packer;
	import ccrp_pkg::*;

	localparam int          QUIET_CYCLES = 40;
	localparam int          CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_ITEMS = 1530;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  op;
	logic [31:0] chunk_bytes;
	logic [31:0] chunk_total_bytes;
	logic [31:0] chunk_src_offset;
	logic [47:0] chunk_addr;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [31:0] raft_offset;
	logic [31:0] length;
	logic [31:0] src_offset;
	logic [47:0] target_addr;
	logic [31:0] target_bytes;
	logic [31:0] launch_bytes;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	command_chunk_raft_packer i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predicted configuration and layout state
	logic [31:0] c_max_stream = RAFT_BYTES;
	logic [15:0] c_min_post   = 16'd16;
	logic [4:0]  c_size_lg    = 5'd2;
	logic [4:0]  c_addr_lg    = 5'd2;
	logic [31:0] p_free       = '0;
	logic [31:0] p_buf_ofs    = '0;
	logic [31:0] p_buf_used   = '0;
	logic [31:0] p_buf_room   = '0;
	logic [31:0] p_post_ofs   = '0;
	logic [31:0] p_post_len   = '0;
	logic [31:0] p_launch     = '0;
	logic        p_closed     = 1'b0;

	result_t     awaited_layout[$];
	int unsigned items_sent    = 0;
	int unsigned mismatches    = 0;
	int unsigned results_seen  = 0;
	int unsigned cycle_count   = 0;
	int          hold_request  = 0;
	bit          tx_gaps       = 1'b1;
	bit          rx_stalls     = 1'b1;

	function automatic logic [31:0] round_up(logic [63:0] v, logic [4:0] lg);
		logic [63:0] m;
		logic [63:0] s;
		m = (64'd1 << lg) - 64'd1;
		s = (v + m) & ~m;
		return (s > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] floor_sub(logic [31:0] a, logic [31:0] b);
		return (a > b) ? a - b : 32'd0;
	endfunction

	function automatic logic [31:0] lesser(logic [31:0] a, logic [31:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic result_t layout_result(kind_t k, logic [31:0] ofs, logic [31:0] len,
			logic [31:0] src, logic [47:0] tgt, logic [31:0] tbytes, logic [31:0] launch);
		result_t r;
		r.kind         = k;
		r.raft_offset  = ofs;
		r.length       = len;
		r.src_offset   = src;
		r.target_addr  = tgt;
		r.target_bytes = tbytes;
		r.launch_bytes = launch;
		r.last         = 1'b0;
		return r;
	endfunction

	// ends the open buffer, patching the previous postamble to chain to it
	function automatic void close_open_buffer();
		logic [31:0] total;
		total = round_up({32'd0, p_buf_used} + {48'd0, c_min_post}, c_size_lg);
		if (p_launch == 32'd0)
			p_launch = total;
		if (p_post_len > 32'd0)
			awaited_layout.push_back(layout_result(KIND_PATCH, p_post_ofs, p_post_len, '0,
				{16'd0, p_buf_ofs}, total, '0));
		p_post_ofs = p_free;
		p_post_len = floor_sub(total, p_buf_used);
		p_buf_ofs  = '0;
		p_buf_used = '0;
		p_buf_room = '0;
		p_free     = round_up({32'd0, p_free} + {32'd0, p_post_len}, c_addr_lg);
	endfunction

	task automatic predict_layout(op_t o, logic [31:0] cb, logic [31:0] ctot, logic [31:0] csrc,
			logic [47:0] caddr);
		int          n_before;
		logic [31:0] ofs;
		logic [31:0] len;
		logic [31:0] remaining;
		result_t     r;
		n_before = awaited_layout.size();
		case (o)
			OP_BEGIN: begin
				p_free     = '0;
				p_buf_ofs  = '0;
				p_buf_used = '0;
				p_buf_room = floor_sub(lesser(c_max_stream, RAFT_BYTES), {16'd0, c_min_post});
				p_post_ofs = '0;
				p_post_len = '0;
				p_launch   = '0;
				p_closed   = 1'b0;
			end
			OP_FINISH: begin
				ofs = '0;
				len = '0;
				if (p_buf_used > 32'd0) begin
					close_open_buffer();
					ofs = p_post_ofs;
					len = p_post_len;
				end
				awaited_layout.push_back(layout_result(KIND_DONE, ofs, len, '0, '0, '0, p_launch));
				p_closed = 1'b1;
			end
			OP_CHUNK: begin
				if (p_closed) begin
					awaited_layout.push_back(layout_result(KIND_REJECT, '0, '0, '0, '0, '0, '0));
				end else begin
					if (cb > p_buf_room) begin
						close_open_buffer();
						remaining = floor_sub(RAFT_BYTES, p_free);
						if (remaining > round_up({48'd0, c_min_post}, c_size_lg)) begin
							p_buf_ofs  = p_free;
							p_buf_room = floor_sub(lesser(c_max_stream, remaining),
								{16'd0, c_min_post});
						end
					end
					if (cb > p_buf_room) begin
						// no room left: chain straight to the chunk and close the stream
						awaited_layout.push_back(layout_result(KIND_PATCH, p_post_ofs, p_post_len,
							'0, caddr, ctot, '0));
						p_closed = 1'b1;
					end else begin
						awaited_layout.push_back(layout_result(KIND_COPY, p_free, cb, csrc,
							'0, '0, '0));
						p_free     = sat_add(p_free, cb);
						p_buf_used = sat_add(p_buf_used, cb);
						p_buf_room = p_buf_room - cb;
					end
				end
			end
			default: ;
		endcase
		if (awaited_layout.size() > n_before) begin
			r = awaited_layout.pop_back();
			r.last = 1'b1;
			awaited_layout.push_back(r);
		end
	endtask

	function automatic logic [47:0] random_addr();
		logic [31:0] hi;
		hi = $urandom;
		return {hi[15:0], 32'($urandom)};
	endfunction

	// chunk sizes scaled to the buffer limit so closes and chains both happen often
	function automatic logic [31:0] pick_chunk_bytes();
		logic [31:0] scale;
		int unsigned r;
		scale = lesser(c_max_stream, RAFT_BYTES);
		if (scale < 32'd64)
			scale = 32'd64;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom;
		if (r < 13)
			return 32'd0;
		if (r < 63)
			return $urandom_range(0, scale >> 2);
		return $urandom_range(scale >> 2, scale + (scale >> 3));
	endfunction

	task automatic send_request(op_t o, logic [31:0] cb, logic [31:0] ctot, logic [31:0] csrc,
			logic [47:0] caddr);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 18) : 0;
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push              <= 1'b1;
		op                <= o;
		chunk_bytes       <= cb;
		chunk_total_bytes <= ctot;
		chunk_src_offset  <= csrc;
		chunk_addr        <= caddr;
		do
			@(posedge clk);
		while (full);
		predict_layout(o, cb, ctot, csrc, caddr);
		if (o != OP_NOP)
			items_sent++;
	endtask

	task automatic send_chunk(logic [31:0] cb);
		send_request(OP_CHUNK, cb, $urandom, $urandom, random_addr());
	endtask

	task automatic send_control(op_t o);
		send_request(o, $urandom, $urandom, $urandom, random_addr());
	endtask

	task automatic wait_for_results(int quiet);
		@(negedge clk);
		push <= 1'b0;
		while (awaited_layout.size() != 0)
			@(posedge clk);
		repeat (quiet) @(posedge clk);
	endtask

	task automatic write_register(cfg_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_MAX_STREAM: c_max_stream = data;
			CFG_MIN_POST:   c_min_post   = data[15:0];
			CFG_SIZE_ALIGN: c_size_lg    = data[4:0];
			CFG_ADDR_ALIGN: c_addr_lg    = data[4:0];
			default: ;
		endcase
	endtask

	// upper bits beyond each register's width carry junk that must be dropped
	task automatic configure(logic [31:0] max_stream, logic [15:0] min_post, logic [4:0] size_lg,
			logic [4:0] addr_lg);
		logic [31:0] junk;
		junk = $urandom;
		write_register(CFG_MAX_STREAM, max_stream);
		write_register(CFG_MIN_POST, {junk[31:16], min_post});
		write_register(CFG_SIZE_ALIGN, {junk[26:0], size_lg});
		write_register(CFG_ADDR_ALIGN, {junk[31:5], addr_lg});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, plus long hold-offs on request
	initial begin : result_sink
		int stall;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			while (hold_request > 0) begin
				@(negedge clk);
				pop <= 1'b0;
				hold_request--;
			end
			stall = rx_stalls ? $urandom_range(0, 18) : 0;
			repeat (stall) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do
				@(posedge clk);
			while (empty);
		end
	end

	function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %0h, got %0h", results_seen, what, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_layout.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: kind %0d arrived with nothing awaited", results_seen,
						kind);
			end else begin
				want = awaited_layout.pop_front();
				check_field("kind", 64'(want.kind), 64'(kind));
				check_field("raft_offset", 64'(want.raft_offset), 64'(raft_offset));
				check_field("length", 64'(want.length), 64'(length));
				check_field("src_offset", 64'(want.src_offset), 64'(src_offset));
				check_field("target_addr", 64'(want.target_addr), 64'(target_addr));
				check_field("target_bytes", 64'(want.target_bytes), 64'(target_bytes));
				check_field("launch_bytes", 64'(want.launch_bytes), 64'(launch_bytes));
				check_field("last", 64'(want.last), 64'(last));
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_command_chunk_raft_packer: FAIL");
			$finish;
		end
	end

	// reset defaults in place, no begin yet: the first chunk closes an empty buffer
	task automatic test_chunk_before_begin();
		send_chunk(32'd100);
		send_chunk(32'd0);
		send_control(OP_FINISH);
	endtask

	task automatic test_every_op_extremes();
		send_control(OP_BEGIN);
		send_chunk(32'd0);
		send_request(OP_CHUNK, 32'd1, '1, '1, '1);
		send_request(OP_NOP, '1, '1, '1, '1);
		send_request(OP_CHUNK, '1, '1, '1, '1);
		send_request(OP_CHUNK, '0, '0, '0, '0);
		send_control(OP_FINISH);
		send_control(OP_FINISH);
	endtask

	// zero limit and zero postamble: chain request with length 0
	task automatic test_zero_postamble();
		wait_for_results(QUIET_CYCLES);
		configure('0, '0, '0, '0);
		send_control(OP_BEGIN);
		send_chunk(32'd5);
		send_control(OP_FINISH);
	endtask

	task automatic test_chained_buffers();
		wait_for_results(QUIET_CYCLES);
		configure(32'd64, 16'd8, 5'd3, 5'd4);
		send_control(OP_BEGIN);
		send_chunk(32'd40);
		send_chunk(32'd30);
		send_chunk(32'd50);
		send_chunk(32'd10);
		send_control(OP_FINISH);
	endtask

	task automatic test_wide_alignment();
		wait_for_results(QUIET_CYCLES);
		configure(RAFT_BYTES, 16'd16, 5'd31, 5'd31);
		send_control(OP_BEGIN);
		send_chunk(32'd8);
		send_chunk(32'h0010_0000);
		send_control(OP_FINISH);
	endtask

	task automatic test_receiver_hold();
		wait_for_results(QUIET_CYCLES);
		configure(RAFT_BYTES, 16'd16, 5'd2, 5'd2);
		tx_gaps      = 1'b0;
		hold_request = 400;
		send_control(OP_BEGIN);
		repeat (16) send_chunk($urandom_range(1, 4096));
		send_control(OP_FINISH);
		tx_gaps = 1'b1;
	endtask

	task automatic test_sender_pause();
		send_control(OP_BEGIN);
		repeat (5) send_chunk($urandom_range(1, 300000));
		wait_for_results(0);
		repeat (5) send_chunk($urandom_range(1, 300000));
		send_control(OP_FINISH);
	endtask

	task automatic run_random_streams(int unsigned phase_items);
		int unsigned stop_at;
		int unsigned n;
		stop_at = items_sent + phase_items;
		while (items_sent < stop_at) begin
			tx_gaps   = $urandom_range(0, 3) != 0;
			rx_stalls = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) < 8) begin
				send_control(OP_BEGIN);
				n = $urandom_range(1, 12);
				repeat (n) send_chunk(pick_chunk_bytes());
				if ($urandom_range(0, 7) != 0)
					send_control(OP_FINISH);
				if ($urandom_range(0, 5) == 0)
					send_chunk(pick_chunk_bytes());
			end else begin
				send_request(op_t'($urandom_range(0, 3)), pick_chunk_bytes(), $urandom, $urandom,
					random_addr());
			end
		end
	endtask

	task automatic test_random_streams();
		for (int p = 0; p < 10; p++) begin
			wait_for_results(QUIET_CYCLES);
			case (p)
				0: configure(RAFT_BYTES, 16'd16, 5'd2, 5'd2);
				1: configure(32'd4096, 16'd32, 5'd4, 5'd6);
				2: configure('0, '0, '0, '0);
				3: configure('1, '1, 5'd16, 5'd16);
				4: configure(32'd256, 16'd8, 5'd3, 5'd3);
				5: configure(RAFT_BYTES, '0, 5'd31, '0);
				7: configure(32'd1024, 16'd64, 5'd5, 5'd12);
				8: configure('1, '0, '0, 5'd31);
				default: configure($urandom_range(64, 2 * RAFT_BYTES),
					16'($urandom_range(0, 512)), 5'($urandom_range(0, 8)),
					5'($urandom_range(0, 12)));
			endcase
			run_random_streams(RANDOM_ITEMS / 10);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		push              = 1'b0;
		op                = OP_BEGIN;
		chunk_bytes       = '0;
		chunk_total_bytes = '0;
		chunk_src_offset  = '0;
		chunk_addr        = '0;
		cfg_valid         = 1'b0;
		cfg_index         = CFG_MAX_STREAM;
		cfg_data          = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_chunk_before_begin();
		test_every_op_extremes();
		test_zero_postamble();
		test_chained_buffers();
		test_wide_alignment();
		test_receiver_hold();
		test_sender_pause();
		test_random_streams();

		wait_for_results(QUIET_CYCLES);
		if (mismatches == 0)
			$display("tb_command_chunk_raft_packer: PASS");
		else
			$display("tb_command_chunk_raft_packer: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/ccrp_pkg.sv
rtl/core/ccrp_front.sv
rtl/core/ccrp_exec.sv
rtl/core/ccrp_outq.sv
rtl/core/command_chunk_raft_packer.sv
tb/tb_command_chunk_raft_packer.sv
